// ===== src/cdate_pkg.sv =====
// ----------------------------------------------------------------------------
// cdate_pkg
// Shared types, constants and calendar helpers for the date counter.
// ----------------------------------------------------------------------------
`default_nettype none

package cdate_pkg;

   localparam int YEAR_W  = 12;
   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int COUNT_W = 16;

   localparam logic [YEAR_W-1:0]  YEAR_TOP     = '1;
   localparam logic [YEAR_W-1:0]  YEAR_SET_MIN = YEAR_W'(1900);
   localparam logic [YEAR_W-1:0]  YEAR_SET_MAX = YEAR_W'(2100);
   localparam logic [MONTH_W-1:0] MONTH_JAN    = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] MONTH_DEC    = MONTH_W'(12);
   localparam logic [DAY_W-1:0]   DAY_FIRST    = DAY_W'(1);
   localparam logic [DAY_W-1:0]   DAY_LONG     = DAY_W'(31);

   // floor(y / 100) as (y * CENT_RECIP) >> CENT_SHIFT, exact for all 12-bit years
   localparam int              CENT_SHIFT = 19;
   localparam logic [12:0]     CENT_RECIP = 13'd5243;
   localparam int              PROD_W     = YEAR_W + 13;
   localparam int              QUOT_W     = PROD_W - CENT_SHIFT;

   typedef enum logic [2:0] {
      REQ_SET  = 3'd0,
      REQ_NEXT = 3'd1,
      REQ_PREV = 3'd2,
      REQ_ADD  = 3'd3,
      REQ_SUB  = 3'd4
   } req_kind_type;

   typedef struct packed {
      logic take;
      logic step;
      logic out_direct;
      logic out_held;
   } ctl_cmd_type;

   typedef struct packed {
      logic run_req;
      logic step_fail;
      logic step_last;
   } ctl_stat_type;

   function automatic logic is_leap(input logic [YEAR_W-1:0] y);
      logic [PROD_W-1:0] prod;
      logic [QUOT_W-1:0] q;
      logic [YEAR_W-1:0] back;
      logic              century;
      prod    = PROD_W'(y) * PROD_W'(CENT_RECIP);
      q       = prod[PROD_W-1:CENT_SHIFT];
      back    = (YEAR_W'(q) << 6) + (YEAR_W'(q) << 5) + (YEAR_W'(q) << 2);
      century = (back == y);
      return (y[1:0] == 2'b00) && (!century || (q[1:0] == 2'b00));
   endfunction

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         MONTH_FEB:                       len = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11:         len = DAY_W'(30);
         default:                         len = DAY_LONG;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== src/cdate_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdate_ctrl
// Transaction sequencing: accept, day-by-day runs, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none

module cdate_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire cdate_pkg::ctl_stat_type stat,
   output cdate_pkg::ctl_cmd_type      cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_HOLD
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (stat.run_req) begin
                  state_in = ST_RUN;
               end else if (slot_free) begin
                  cmd.out_direct = 1'b1;
                  rsp_valid_in   = 1'b1;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (stat.step_fail || stat.step_last) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               cmd.out_held = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/cdate_datapath.sv =====
// ----------------------------------------------------------------------------
// cdate_datapath
// Date registers, single-day step logic, set validation and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cdate_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [2:0]                        req_type,
   input  wire logic [cdate_pkg::MONTH_W-1:0]     req_month_in,
   input  wire logic [cdate_pkg::DAY_W-1:0]       req_day_in,
   input  wire logic [cdate_pkg::YEAR_W-1:0]      req_year_in,
   input  wire logic [cdate_pkg::COUNT_W-1:0]     req_step_count,
   input  wire cdate_pkg::ctl_cmd_type            cmd,
   output cdate_pkg::ctl_stat_type                stat,
   output logic [cdate_pkg::DAY_W-1:0]            rsp_day_now,
   output logic [cdate_pkg::MONTH_W-1:0]          rsp_month_now,
   output logic [cdate_pkg::YEAR_W-1:0]           rsp_year_now,
   output logic [cdate_pkg::DAY_W-1:0]            rsp_day_before,
   output logic [cdate_pkg::MONTH_W-1:0]          rsp_month_before,
   output logic [cdate_pkg::YEAR_W-1:0]           rsp_year_before,
   output logic                                   rsp_range_error
);

   localparam int DW = cdate_pkg::DAY_W;
   localparam int MW = cdate_pkg::MONTH_W;
   localparam int YW = cdate_pkg::YEAR_W;
   localparam int CW = cdate_pkg::COUNT_W;

   logic [DW-1:0] cur_day_ff, cur_day_in;
   logic [MW-1:0] cur_month_ff, cur_month_in;
   logic [YW-1:0] cur_year_ff, cur_year_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [DW-1:0] bef_day_ff, bef_day_in;
   logic [MW-1:0] bef_month_ff, bef_month_in;
   logic [YW-1:0] bef_year_ff, bef_year_in;
   logic          err_ff, err_in;
   logic          dir_back_ff, dir_back_in;

   logic [DW-1:0] out_day_now_ff, out_day_now_in;
   logic [MW-1:0] out_month_now_ff, out_month_now_in;
   logic [YW-1:0] out_year_now_ff, out_year_now_in;
   logic [DW-1:0] out_day_bef_ff, out_day_bef_in;
   logic [MW-1:0] out_month_bef_ff, out_month_bef_in;
   logic [YW-1:0] out_year_bef_ff, out_year_bef_in;
   logic          out_err_ff, out_err_in;

   logic          leap_cur, leap_set;
   logic [DW-1:0] len_cur;

   logic [DW-1:0] fwd_day, bwd_day, set_day, imm_day, run_day;
   logic [MW-1:0] fwd_month, bwd_month, set_month, imm_month, run_month;
   logic [YW-1:0] fwd_year, bwd_year, set_year, imm_year, run_year;
   logic          fwd_fail, bwd_fail, imm_err, run_fail;
   logic          is_run_kind;

   assign leap_cur = cdate_pkg::is_leap(cur_year_ff);
   assign len_cur  = cdate_pkg::month_days(cur_month_ff, leap_cur);

   // one day forward
   always_comb begin
      fwd_day   = cur_day_ff;
      fwd_month = cur_month_ff;
      fwd_year  = cur_year_ff;
      fwd_fail  = 1'b0;
      if (cur_day_ff < len_cur) begin
         fwd_day = cur_day_ff + DW'(1);
      end else if (cur_month_ff < cdate_pkg::MONTH_DEC) begin
         fwd_month = cur_month_ff + MW'(1);
         fwd_day   = cdate_pkg::DAY_FIRST;
      end else if (cur_year_ff == cdate_pkg::YEAR_TOP) begin
         fwd_fail = 1'b1;
      end else begin
         fwd_year  = cur_year_ff + YW'(1);
         fwd_month = cdate_pkg::MONTH_JAN;
         fwd_day   = cdate_pkg::DAY_FIRST;
      end
   end

   // one day back; stepping into a new year lands on 31 December
   always_comb begin
      bwd_day   = cur_day_ff;
      bwd_month = cur_month_ff;
      bwd_year  = cur_year_ff;
      bwd_fail  = 1'b0;
      if (cur_day_ff > cdate_pkg::DAY_FIRST) begin
         bwd_day = cur_day_ff - DW'(1);
      end else if (cur_month_ff > cdate_pkg::MONTH_JAN) begin
         bwd_month = cur_month_ff - MW'(1);
         bwd_day   = cdate_pkg::month_days(cur_month_ff - MW'(1), leap_cur);
      end else if (cur_year_ff == '0) begin
         bwd_fail = 1'b1;
      end else begin
         bwd_year  = cur_year_ff - YW'(1);
         bwd_month = cdate_pkg::MONTH_DEC;
         bwd_day   = cdate_pkg::DAY_LONG;
      end
   end

   // set with validation
   always_comb begin
      set_month = ((req_month_in >= cdate_pkg::MONTH_JAN) &&
                   (req_month_in <= cdate_pkg::MONTH_DEC)) ? req_month_in
                                                           : cdate_pkg::MONTH_JAN;
      set_year  = ((req_year_in >= cdate_pkg::YEAR_SET_MIN) &&
                   (req_year_in <= cdate_pkg::YEAR_SET_MAX)) ? req_year_in
                                                            : cdate_pkg::YEAR_SET_MIN;
      leap_set  = cdate_pkg::is_leap(set_year);
      set_day   = ((req_day_in >= cdate_pkg::DAY_FIRST) &&
                   (req_day_in <= cdate_pkg::month_days(set_month, leap_set)))
                  ? req_day_in : cdate_pkg::DAY_FIRST;
   end

   always_comb begin
      imm_day     = cur_day_ff;
      imm_month   = cur_month_ff;
      imm_year    = cur_year_ff;
      imm_err     = 1'b0;
      is_run_kind = 1'b0;
      case (cdate_pkg::req_kind_type'(req_type))
         cdate_pkg::REQ_SET: begin
            imm_day   = set_day;
            imm_month = set_month;
            imm_year  = set_year;
         end
         cdate_pkg::REQ_NEXT: begin
            imm_day   = fwd_day;
            imm_month = fwd_month;
            imm_year  = fwd_year;
            imm_err   = fwd_fail;
         end
         cdate_pkg::REQ_PREV: begin
            imm_day   = bwd_day;
            imm_month = bwd_month;
            imm_year  = bwd_year;
            imm_err   = bwd_fail;
         end
         cdate_pkg::REQ_ADD, cdate_pkg::REQ_SUB: begin
            is_run_kind = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign run_day   = dir_back_ff ? bwd_day   : fwd_day;
   assign run_month = dir_back_ff ? bwd_month : fwd_month;
   assign run_year  = dir_back_ff ? bwd_year  : fwd_year;
   assign run_fail  = dir_back_ff ? bwd_fail  : fwd_fail;

   assign stat.run_req   = is_run_kind && (req_step_count != '0);
   assign stat.step_fail = run_fail;
   assign stat.step_last = (steps_ff == CW'(1));

   always_comb begin
      cur_day_in   = cur_day_ff;
      cur_month_in = cur_month_ff;
      cur_year_in  = cur_year_ff;
      steps_in     = steps_ff;
      bef_day_in   = bef_day_ff;
      bef_month_in = bef_month_ff;
      bef_year_in  = bef_year_ff;
      err_in       = err_ff;
      dir_back_in  = dir_back_ff;
      if (cmd.take) begin
         bef_day_in   = cur_day_ff;
         bef_month_in = cur_month_ff;
         bef_year_in  = cur_year_ff;
         cur_day_in   = imm_day;
         cur_month_in = imm_month;
         cur_year_in  = imm_year;
         err_in       = imm_err;
         steps_in     = req_step_count;
         dir_back_in  = (req_type == cdate_pkg::REQ_SUB);
      end else if (cmd.step) begin
         if (run_fail) begin
            err_in   = 1'b1;
            steps_in = '0;
         end else begin
            cur_day_in   = run_day;
            cur_month_in = run_month;
            cur_year_in  = run_year;
            steps_in     = steps_ff - CW'(1);
         end
      end
   end

   always_comb begin
      out_day_now_in   = out_day_now_ff;
      out_month_now_in = out_month_now_ff;
      out_year_now_in  = out_year_now_ff;
      out_day_bef_in   = out_day_bef_ff;
      out_month_bef_in = out_month_bef_ff;
      out_year_bef_in  = out_year_bef_ff;
      out_err_in       = out_err_ff;
      if (cmd.out_direct) begin
         out_day_now_in   = imm_day;
         out_month_now_in = imm_month;
         out_year_now_in  = imm_year;
         out_day_bef_in   = cur_day_ff;
         out_month_bef_in = cur_month_ff;
         out_year_bef_in  = cur_year_ff;
         out_err_in       = imm_err;
      end else if (cmd.out_held) begin
         out_day_now_in   = cur_day_ff;
         out_month_now_in = cur_month_ff;
         out_year_now_in  = cur_year_ff;
         out_day_bef_in   = bef_day_ff;
         out_month_bef_in = bef_month_ff;
         out_year_bef_in  = bef_year_ff;
         out_err_in       = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_day_ff   <= cdate_pkg::DAY_FIRST;
         cur_month_ff <= cdate_pkg::MONTH_JAN;
         cur_year_ff  <= cdate_pkg::YEAR_SET_MIN;
         steps_ff     <= '0;
      end else begin
         cur_day_ff   <= cur_day_in;
         cur_month_ff <= cur_month_in;
         cur_year_ff  <= cur_year_in;
         steps_ff     <= steps_in;
      end
   end

   always_ff @(posedge clock) begin
      bef_day_ff       <= bef_day_in;
      bef_month_ff     <= bef_month_in;
      bef_year_ff      <= bef_year_in;
      err_ff           <= err_in;
      dir_back_ff      <= dir_back_in;
      out_day_now_ff   <= out_day_now_in;
      out_month_now_ff <= out_month_now_in;
      out_year_now_ff  <= out_year_now_in;
      out_day_bef_ff   <= out_day_bef_in;
      out_month_bef_ff <= out_month_bef_in;
      out_year_bef_ff  <= out_year_bef_in;
      out_err_ff       <= out_err_in;
   end

   assign rsp_day_now      = out_day_now_ff;
   assign rsp_month_now    = out_month_now_ff;
   assign rsp_year_now     = out_year_now_ff;
   assign rsp_day_before   = out_day_bef_ff;
   assign rsp_month_before = out_month_bef_ff;
   assign rsp_year_before  = out_year_bef_ff;
   assign rsp_range_error  = out_err_ff;

endmodule

`default_nettype wire

// ===== src/calendar_date_counter_core.sv =====
// ----------------------------------------------------------------------------
// calendar_date_counter_core
// Gregorian date counter: set, single-day and multi-day steps with range hold.
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | type, month, day, year, count
//   rsp_    | out       | rsp_valid/rsp_stall  | date now, date before, error
//
// Set, next, previous, spare-code and zero-count transactions: no stepping; the
// result is loaded into the output register on acceptance.
// Add/subtract of N days: one day stepped per cycle until N days are done or a step
// is held at a range edge, then the result is handed over; input stalled until then.
// Reset gives 1 January 1900 and an empty output register.
// A transaction accepted while the output is stalled waits until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_counter_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [2:0]                     req_type,
   input  wire logic [cdate_pkg::MONTH_W-1:0]  req_month_in,
   input  wire logic [cdate_pkg::DAY_W-1:0]    req_day_in,
   input  wire logic [cdate_pkg::YEAR_W-1:0]   req_year_in,
   input  wire logic [cdate_pkg::COUNT_W-1:0]  req_step_count,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [cdate_pkg::DAY_W-1:0]         rsp_day_now,
   output logic [cdate_pkg::MONTH_W-1:0]       rsp_month_now,
   output logic [cdate_pkg::YEAR_W-1:0]        rsp_year_now,
   output logic [cdate_pkg::DAY_W-1:0]         rsp_day_before,
   output logic [cdate_pkg::MONTH_W-1:0]       rsp_month_before,
   output logic [cdate_pkg::YEAR_W-1:0]        rsp_year_before,
   output logic                                rsp_range_error
);

   cdate_pkg::ctl_cmd_type  cmd;
   cdate_pkg::ctl_stat_type stat;

   cdate_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cdate_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_type         (req_type),
      .req_month_in     (req_month_in),
      .req_day_in       (req_day_in),
      .req_year_in      (req_year_in),
      .req_step_count   (req_step_count),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_day_now      (rsp_day_now),
      .rsp_month_now    (rsp_month_now),
      .rsp_year_now     (rsp_year_now),
      .rsp_day_before   (rsp_day_before),
      .rsp_month_before (rsp_month_before),
      .rsp_year_before  (rsp_year_before),
      .rsp_range_error  (rsp_range_error)
   );

   // a held step only ever stops at one of the two range edges
   a_err_at_edge : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |->
         ((rsp_day_now == cdate_pkg::DAY_FIRST) && (rsp_month_now == cdate_pkg::MONTH_JAN) &&
          (rsp_year_now == '0)) ||
         ((rsp_day_now == cdate_pkg::DAY_LONG) && (rsp_month_now == cdate_pkg::MONTH_DEC) &&
          (rsp_year_now == cdate_pkg::YEAR_TOP)))
      else $error("range error reported away from the year range edges");

   a_date_legal : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_month_now >= cdate_pkg::MONTH_JAN) &&
                    (rsp_month_now <= cdate_pkg::MONTH_DEC) &&
                    (rsp_day_now >= cdate_pkg::DAY_FIRST))
      else $error("result date out of range");

   a_set_result : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_type == cdate_pkg::REQ_SET) &&
       (!rsp_valid || !rsp_stall))
      |=> rsp_valid && !rsp_range_error &&
          (rsp_year_now >= cdate_pkg::YEAR_SET_MIN) &&
          (rsp_year_now <= cdate_pkg::YEAR_SET_MAX))
      else $error("set transaction result missing or out of the set range");

endmodule

`default_nettype wire

// ===== tb/calendar_date_checker.sv =====
// ----------------------------------------------------------------------------
// calendar_date_checker
// Watches both channels of the date counter. It keeps its own copy of the
// calendar, works out the date pair and range flag for every accepted
// request, and matches each accepted response against the oldest
// outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire logic [2:0]                     req_type,
   input  wire logic [cdate_pkg::MONTH_W-1:0]  req_month_in,
   input  wire logic [cdate_pkg::DAY_W-1:0]    req_day_in,
   input  wire logic [cdate_pkg::YEAR_W-1:0]   req_year_in,
   input  wire logic [cdate_pkg::COUNT_W-1:0]  req_step_count,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire logic [cdate_pkg::DAY_W-1:0]    rsp_day_now,
   input  wire logic [cdate_pkg::MONTH_W-1:0]  rsp_month_now,
   input  wire logic [cdate_pkg::YEAR_W-1:0]   rsp_year_now,
   input  wire logic [cdate_pkg::DAY_W-1:0]    rsp_day_before,
   input  wire logic [cdate_pkg::MONTH_W-1:0]  rsp_month_before,
   input  wire logic [cdate_pkg::YEAR_W-1:0]   rsp_year_before,
   input  wire logic                           rsp_range_error,
   output int                                  fail_count,
   output int                                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   import cdate_pkg::*;

   typedef struct packed {
      logic [DAY_W-1:0]   day_now;
      logic [MONTH_W-1:0] month_now;
      logic [YEAR_W-1:0]  year_now;
      logic [DAY_W-1:0]   day_before;
      logic [MONTH_W-1:0] month_before;
      logic [YEAR_W-1:0]  year_before;
      logic               range_error;
   } date_result_type;

   logic [DAY_W-1:0]   cal_day   = DAY_FIRST;
   logic [MONTH_W-1:0] cal_month = MONTH_JAN;
   logic [YEAR_W-1:0]  cal_year  = YEAR_SET_MIN;

   date_result_type dates_due[$];
   int           fails      = 0;
   int           mismatches = 0;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic bit leap_year(input int unsigned y);
      return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
   endfunction

   function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
      case (m)
         2:           return leap_year(y) ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   // one day on; 0 means the date is held at the top year
   function automatic bit roll_forward();
      if (cal_day < days_in_month(cal_month, cal_year)) begin
         cal_day++;
      end else if (cal_month < MONTH_DEC) begin
         cal_month++;
         cal_day = DAY_FIRST;
      end else if (cal_year == YEAR_TOP) begin
         return 1'b0;
      end else begin
         cal_year++;
         cal_month = MONTH_JAN;
         cal_day   = DAY_FIRST;
      end
      return 1'b1;
   endfunction

   // one day back; 0 means the date is held at 1 January of year 0
   function automatic bit roll_back();
      if (cal_day > DAY_FIRST) begin
         cal_day--;
         return 1'b1;
      end
      if (cal_month > MONTH_JAN) begin
         cal_month--;
      end else if (cal_year == '0) begin
         return 1'b0;
      end else begin
         cal_year--;
         cal_month = MONTH_DEC;
      end
      cal_day = DAY_W'(days_in_month(cal_month, cal_year));
      return 1'b1;
   endfunction

   function automatic date_result_type apply_request(input logic [2:0] kind,
                                                     input logic [MONTH_W-1:0] m,
                                                     input logic [DAY_W-1:0] d,
                                                     input logic [YEAR_W-1:0] y,
                                                     input logic [COUNT_W-1:0] cnt);
      date_result_type r;
      int unsigned     left;
      bit              ok;
      r.day_before   = cal_day;
      r.month_before = cal_month;
      r.year_before  = cal_year;
      r.range_error  = 1'b0;
      case (kind)
         REQ_SET: begin
            cal_month = (m >= MONTH_JAN && m <= MONTH_DEC) ? m : MONTH_JAN;
            cal_year  = (y >= YEAR_SET_MIN && y <= YEAR_SET_MAX) ? y : YEAR_SET_MIN;
            cal_day   = (d >= DAY_FIRST && d <= days_in_month(cal_month, cal_year)) ?
                        d : DAY_FIRST;
         end
         REQ_NEXT: r.range_error = !roll_forward();
         REQ_PREV: r.range_error = !roll_back();
         REQ_ADD, REQ_SUB: begin
            left = cnt;
            while (left != 0) begin
               ok = (kind == REQ_ADD) ? roll_forward() : roll_back();
               if (!ok) begin
                  r.range_error = 1'b1;
                  left = 0;
               end else begin
                  left--;
               end
            end
         end
         default: ;
      endcase
      r.day_now   = cal_day;
      r.month_now = cal_month;
      r.year_now  = cal_year;
      return r;
   endfunction

   always @(posedge clock) begin
      date_result_type got;
      date_result_type want;
      if (reset) begin
         cal_day   = DAY_FIRST;
         cal_month = MONTH_JAN;
         cal_year  = YEAR_SET_MIN;
         dates_due.delete();
         pending <= 0;
      end else begin
         // older transactions leave the queue before a new one joins it
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_day_now, rsp_month_now, rsp_year_now, rsp_day_before,
                   rsp_month_before, rsp_year_before, rsp_range_error};
            if (dates_due.size() == 0) begin
               fails++;
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response %0d-%0d-%0d at %0t",
                           got.year_now, got.month_now, got.day_now, $realtime);
            end else begin
               want = dates_due.pop_front();
               if (got !== want) begin
                  fails++;
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"date mismatch: expected %0d-%0d-%0d (was %0d-%0d-%0d, err %0b)",
                               ", got %0d-%0d-%0d (was %0d-%0d-%0d, err %0b)"},
                              want.year_now, want.month_now, want.day_now,
                              want.year_before, want.month_before, want.day_before,
                              want.range_error,
                              got.year_now, got.month_now, got.day_now,
                              got.year_before, got.month_before, got.day_before,
                              got.range_error);
               end
            end
         end
         if (req_valid && !req_stall)
            dates_due.push_back(apply_request(req_type, req_month_in, req_day_in,
                                              req_year_in, req_step_count));
         pending <= dates_due.size();
      end
      fail_count <= fails;
   end

endmodule

`default_nettype wire

// ===== tb/calendar_date_counter_core_tb.sv =====
// ----------------------------------------------------------------------------
// calendar_date_counter_core_tb
// Drives the date counter with a directed sweep (validation of set dates,
// leap and century rules, zero and full-size runs down to year 0 and up to
// the top year) followed by random transactions with random gaps and
// response stalls. Checking is left to the checker beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_counter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cdate_pkg::*;

   localparam time CLK_PERIOD    = 8ns;
   localparam int  CYCLE_LIMIT   = 10_000_000;
   localparam int  RANDOM_ITEMS  = 1900;
   localparam logic [2:0] REQ_UNUSED_MIN = 3'd5;
   localparam logic [2:0] REQ_UNUSED_MAX = 3'd7;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [2:0]          req_type       = '0;
   logic [MONTH_W-1:0]  req_month_in   = '0;
   logic [DAY_W-1:0]    req_day_in     = '0;
   logic [YEAR_W-1:0]   req_year_in    = '0;
   logic [COUNT_W-1:0]  req_step_count = '0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [DAY_W-1:0]    rsp_day_now;
   logic [MONTH_W-1:0]  rsp_month_now;
   logic [YEAR_W-1:0]   rsp_year_now;
   logic [DAY_W-1:0]    rsp_day_before;
   logic [MONTH_W-1:0]  rsp_month_before;
   logic [YEAR_W-1:0]   rsp_year_before;
   logic                rsp_range_error;

   int  fail_count;
   int  pending;
   int  cycle_count = 0;
   int  hold_left   = 0;
   bit  quiet       = 1'b0;
   int  big_runs    = 0;
   int  n_items     = 0;
   int  n_sets      = 0;
   int  n_single    = 0;
   int  n_runs      = 0;
   int  n_spare     = 0;
   longint n_days   = 0;

   int unsigned marked_years[6] = '{1900, 1903, 1904, 2000, 2099, 2100};

   calendar_date_counter_core u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_month_in     (req_month_in),
      .req_day_in       (req_day_in),
      .req_year_in      (req_year_in),
      .req_step_count   (req_step_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_day_now      (rsp_day_now),
      .rsp_month_now    (rsp_month_now),
      .rsp_year_now     (rsp_year_now),
      .rsp_day_before   (rsp_day_before),
      .rsp_month_before (rsp_month_before),
      .rsp_year_before  (rsp_year_before),
      .rsp_range_error  (rsp_range_error)
   );

   calendar_date_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_month_in     (req_month_in),
      .req_day_in       (req_day_in),
      .req_year_in      (req_year_in),
      .req_step_count   (req_step_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_day_now      (rsp_day_now),
      .rsp_month_now    (rsp_month_now),
      .rsp_year_now     (rsp_year_now),
      .rsp_day_before   (rsp_day_before),
      .rsp_month_before (rsp_month_before),
      .rsp_year_before  (rsp_year_before),
      .rsp_range_error  (rsp_range_error),
      .fail_count       (fail_count),
      .pending          (pending)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[calendar_date_counter_core] ERROR");
         $finish;
      end
   end

   // response side: a fresh hold-off after every accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         hold_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            hold_left = quiet ? 0 : $urandom_range(0, 12);
         else if (hold_left != 0)
            hold_left--;
         rsp_stall <= (hold_left != 0);
      end
   end

   task automatic send_req(input logic [2:0] kind, input logic [MONTH_W-1:0] m,
                           input logic [DAY_W-1:0] d, input logic [YEAR_W-1:0] y,
                           input logic [COUNT_W-1:0] cnt);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_type       <= kind;
      req_month_in   <= m;
      req_day_in     <= d;
      req_year_in    <= y;
      req_step_count <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_items++;
      case (kind)
         REQ_SET:          n_sets++;
         REQ_NEXT, REQ_PREV: n_single++;
         REQ_ADD, REQ_SUB: begin
            n_runs++;
            n_days += cnt;
         end
         default:          n_spare++;
      endcase
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic send_random_item();
      int          pick;
      int          r;
      logic [2:0]  kind;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      logic [YEAR_W-1:0]  y;
      logic [COUNT_W-1:0] cnt;
      pick = $urandom_range(0, 99);
      m    = MONTH_W'($urandom);
      d    = DAY_W'($urandom);
      y    = YEAR_W'($urandom);
      cnt  = COUNT_W'($urandom);
      if (pick < 18) begin
         kind = REQ_SET;
         m    = MONTH_W'($urandom_range(1, 12));
         d    = ($urandom_range(0, 1) == 1) ? DAY_W'($urandom_range(27, 31)) :
                                              DAY_W'($urandom_range(1, 31));
         y    = ($urandom_range(0, 3) == 0) ? YEAR_W'(marked_years[$urandom_range(0, 5)]) :
                                              YEAR_W'($urandom_range(1900, 2100));
      end else if (pick < 23) begin
         kind = REQ_SET;
      end else if (pick < 50) begin
         kind = REQ_NEXT;
      end else if (pick < 75) begin
         kind = REQ_PREV;
      end else if (pick < 97) begin
         kind = (pick < 86) ? REQ_ADD : REQ_SUB;
         r = $urandom_range(0, 199);
         if (r == 0 && big_runs < 3) begin
            cnt = ($urandom_range(0, 1) == 1) ? '1 : COUNT_W'($urandom_range(10000, 65535));
            big_runs++;
         end else if (r < 6) begin
            cnt = COUNT_W'($urandom_range(300, 1500));
         end else begin
            cnt = COUNT_W'($urandom_range(0, 40));
         end
      end else begin
         kind = 3'($urandom_range(REQ_UNUSED_MIN, REQ_UNUSED_MAX));
      end
      send_req(kind, m, d, y, cnt);
   endtask

   initial begin
      int i;
      int k;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // calendar rules and set validation
      send_req(REQ_NEXT, '0, '0, '0, '0);
      send_req(REQ_PREV, '0, '0, '0, '0);
      send_req(REQ_SET, 4'd2, 5'd28, 12'd1900, '0);
      send_req(REQ_NEXT, '0, '0, '0, '0);
      send_req(REQ_SET, 4'd2, 5'd29, 12'd1900, '0);
      send_req(REQ_SET, 4'd2, 5'd29, 12'd2000, '0);
      send_req(REQ_NEXT, '0, '0, '0, '0);
      send_req(REQ_PREV, '0, '0, '0, '0);
      send_req(REQ_SET, 4'd2, 5'd29, 12'd2100, '0);
      send_req(REQ_SET, 4'd0, 5'd31, 12'd0, '0);
      send_req(REQ_SET, 4'd15, 5'd0, 12'd4095, '0);
      send_req(REQ_SET, 4'd4, 5'd31, 12'd2101, '0);
      send_req(REQ_SET, 4'd13, 5'd5, 12'd1899, '0);
      send_req(REQ_SET, 4'd12, 5'd31, 12'd2099, '0);
      send_req(REQ_NEXT, '0, '0, '0, '0);
      send_req(REQ_PREV, '0, '0, '0, '0);
      send_req(REQ_ADD, '0, '0, '0, '0);
      send_req(REQ_SUB, '0, '0, '0, '0);
      send_req(REQ_ADD, '0, '0, '0, 16'd366);
      send_req(REQ_SUB, '0, '0, '0, 16'd366);
      for (k = REQ_UNUSED_MIN; k <= REQ_UNUSED_MAX; k++)
         send_req(3'(k), '1, '1, '1, '1);

      // run down to 1 January of year 0; the last run is cut short
      send_req(REQ_SET, 4'd1, 5'd1, 12'd1900, '0);
      repeat (11) send_req(REQ_SUB, '0, '0, '0, '1);
      send_req(REQ_PREV, '0, '0, '0, '0);
      send_req(REQ_NEXT, '0, '0, '0, '0);
      send_req(REQ_PREV, '0, '0, '0, '0);
      send_req(REQ_PREV, '0, '0, '0, '0);

      // run up to 31 December of the top year
      send_req(REQ_SET, 4'd12, 5'd31, 12'd2100, '0);
      repeat (12) send_req(REQ_ADD, '0, '0, '0, '1);
      send_req(REQ_NEXT, '0, '0, '0, '0);
      send_req(REQ_PREV, '0, '0, '0, '0);
      send_req(REQ_ADD, '0, '0, '0, 16'd5);
      wait_for_drain();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 150 == 0)
            quiet <= ($urandom_range(0, 3) == 0);
         if (i % 400 == 399)
            wait_for_drain();
         send_random_item();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Ran %0d transactions: %0d sets, %0d single-day steps, %0d spare codes,",
               n_items, n_sets, n_single, n_spare);
      $display("and %0d multi-day runs over %0d days, reaching both ends of the year range.",
               n_runs, n_days);
      if (fail_count == 0)
         $display("[calendar_date_counter_core] OK");
      else
         $display("[calendar_date_counter_core] ERROR");
      $finish;
   end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/cdate_pkg.sv
src/cdate_ctrl.sv
src/cdate_datapath.sv
src/calendar_date_counter_core.sv
tb/calendar_date_checker.sv
tb/calendar_date_counter_core_tb.sv
